// ===== rtl/tnorm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnorm_pkg: shared types and constants of the triangle unit normal core
// Item structs, datapath widths and pipeline depths used by every module.
// ----------------------------------------------------------------------------
package tnorm_pkg;

  // Coordinates are taken from the low COORD_BITS of each 32-bit field.
  localparam int COORD_BITS       = 32;
  localparam int NORMAL_FRAC_BITS = 15;

  // The largest cross product magnitude is normalized to this many bits.
  localparam int NORM_BITS = 31;

  localparam int EDGE_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * EDGE_W;
  localparam int DIFF_W = PROD_W + 1;
  localparam int MAG_W  = 2 * COORD_BITS + 1;
  localparam int LEN_W  = $clog2(MAG_W + 1);
  localparam int SQ_W   = 2 * NORM_BITS;
  localparam int SUM_W  = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;

  localparam int OUT_W  = NORMAL_FRAC_BITS + 1;
  localparam int QUO_W  = NORMAL_FRAC_BITS + 1;
  localparam int NUM_W  = NORM_BITS + NORMAL_FRAC_BITS + 2;
  localparam int DEN_W  = ROOT_W + 1;

  localparam int FRONT_STAGES = 7;
  localparam int ISQRT_STAGES = SUM_W / 2;
  localparam int DIV_STAGES   = QUO_W;
  localparam int LATENCY      = FRONT_STAGES + ISQRT_STAGES + DIV_STAGES + 1;

  typedef struct packed {
    logic signed [31:0] v0_x;
    logic signed [31:0] v0_y;
    logic signed [31:0] v0_z;
    logic signed [31:0] v1_x;
    logic signed [31:0] v1_y;
    logic signed [31:0] v1_z;
    logic signed [31:0] v2_x;
    logic signed [31:0] v2_y;
    logic signed [31:0] v2_z;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
  } out_item_t;

  // Per-item information that rides alongside the square root.
  typedef struct packed {
    logic                       zero;
    logic [2:0]                 neg;
    logic [2:0][NORM_BITS-1:0]  m;
  } side_t;

endpackage

// ===== rtl/tnorm_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnorm_isqrt: pipelined integer square root
// One result bit per register stage; a side struct travels with each item.
// ----------------------------------------------------------------------------
module tnorm_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [tnorm_pkg::SUM_W-1:0] in_val,
  input  tnorm_pkg::side_t            in_side,
  output logic                        out_vld,
  output logic [tnorm_pkg::ROOT_W-1:0] out_root,
  output tnorm_pkg::side_t            out_side
);
  import tnorm_pkg::*;

  logic             vld_r  [ISQRT_STAGES];
  logic [SUM_W-1:0] rem_r  [ISQRT_STAGES];
  logic [SUM_W-1:0] res_r  [ISQRT_STAGES];
  side_t            side_r [ISQRT_STAGES];

  for (genvar k = 0; k < ISQRT_STAGES; k++) begin : g_stage
    localparam logic [SUM_W-1:0] PW = SUM_W'(1) << (SUM_W - 2 - 2 * k);
    logic             vld_in;
    logic [SUM_W-1:0] rem_in;
    logic [SUM_W-1:0] res_in;
    side_t            side_in;
    logic [SUM_W-1:0] trial;
    logic [SUM_W-1:0] rem_nxt;
    logic [SUM_W-1:0] res_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = in_val;
      assign res_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign res_in  = res_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      trial = res_in + PW;
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        res_nxt = (res_in >> 1) + PW;
      end else begin
        rem_nxt = rem_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      res_r[k]  <= res_nxt;
      side_r[k] <= side_in;
    end
  end

  assign out_vld  = vld_r[ISQRT_STAGES-1];
  assign out_root = res_r[ISQRT_STAGES-1][ROOT_W-1:0];
  assign out_side = side_r[ISQRT_STAGES-1];

  // The root of a SUM_W-bit value always fits in ROOT_W bits.
  a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> res_r[ISQRT_STAGES-1][SUM_W-1:ROOT_W] == '0)
    else $error("square root result overflowed its width");

endmodule

// ===== rtl/tnorm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnorm_div: pipelined three-lane rounding divider
// Divides each normalized magnitude by the length, one quotient bit per stage,
// then applies sign, saturation and the degenerate-triangle zero.
// ----------------------------------------------------------------------------
module tnorm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [tnorm_pkg::ROOT_W-1:0] in_len,
  input  tnorm_pkg::side_t             in_side,
  output logic                         out_vld,
  output logic                         out_zero,
  output tnorm_pkg::out_item_t         out_item
);
  import tnorm_pkg::*;

  localparam logic [QUO_W-1:0] QMAX = QUO_W'((1 << NORMAL_FRAC_BITS) - 1);
  localparam logic [QUO_W-1:0] QONE = QUO_W'(1 << NORMAL_FRAC_BITS);

  logic             vld_r  [DIV_STAGES];
  logic [NUM_W-1:0] rem_r  [DIV_STAGES][3];
  logic [QUO_W-1:0] quo_r  [DIV_STAGES][3];
  logic [DEN_W-1:0] den_r  [DIV_STAGES];
  logic             zero_r [DIV_STAGES];
  logic [2:0]       neg_r  [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    localparam int K = DIV_STAGES - 1 - j;
    logic             vld_in;
    logic [NUM_W-1:0] rem_in [3];
    logic [QUO_W-1:0] quo_in [3];
    logic [DEN_W-1:0] den_in;
    logic             zero_in;
    logic [2:0]       neg_in;
    logic [NUM_W-1:0] dk;
    logic [NUM_W-1:0] rem_nxt [3];
    logic [QUO_W-1:0] quo_nxt [3];

    if (j == 0) begin : g_first
      assign vld_in  = in_vld;
      assign den_in  = {in_len, 1'b0};
      assign zero_in = in_side.zero;
      assign neg_in  = in_side.neg;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        // Numerator is 2 * m * 2^F + L, so the quotient rounds half away from zero.
        assign rem_in[l] = (NUM_W'(in_side.m[l]) << (NORMAL_FRAC_BITS + 1))
                           + NUM_W'(in_len);
        assign quo_in[l] = '0;
      end
    end else begin : g_next
      assign vld_in  = vld_r[j-1];
      assign den_in  = den_r[j-1];
      assign zero_in = zero_r[j-1];
      assign neg_in  = neg_r[j-1];
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[l] = rem_r[j-1][l];
        assign quo_in[l] = quo_r[j-1][l];
      end
    end

    always_comb begin
      dk = NUM_W'(den_in) << K;
      for (int l = 0; l < 3; l++) begin
        quo_nxt[l] = quo_in[l];
        if (rem_in[l] >= dk) begin
          rem_nxt[l]    = rem_in[l] - dk;
          quo_nxt[l][K] = 1'b1;
        end else begin
          rem_nxt[l] = rem_in[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      den_r[j]  <= den_in;
      zero_r[j] <= zero_in;
      neg_r[j]  <= neg_in;
      for (int l = 0; l < 3; l++) begin
        rem_r[j][l] <= rem_nxt[l];
        quo_r[j][l] <= quo_nxt[l];
      end
    end
  end

  logic [OUT_W-1:0] res [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (zero_r[DIV_STAGES-1]) begin
        res[l] = '0;
      end else if (neg_r[DIV_STAGES-1][l]) begin
        res[l] = OUT_W'(-quo_r[DIV_STAGES-1][l]);
      end else if (quo_r[DIV_STAGES-1][l] > QMAX) begin
        res[l] = OUT_W'(QMAX);
      end else begin
        res[l] = OUT_W'(quo_r[DIV_STAGES-1][l]);
      end
    end
  end

  assign out_vld           = vld_r[DIV_STAGES-1];
  assign out_zero          = zero_r[DIV_STAGES-1];
  assign out_item.normal_x = signed'(res[0]);
  assign out_item.normal_y = signed'(res[1]);
  assign out_item.normal_z = signed'(res[2]);

  // A magnitude never exceeds the length, so no quotient passes one.
  a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_zero |-> quo_r[DIV_STAGES-1][0] <= QONE
      && quo_r[DIV_STAGES-1][1] <= QONE && quo_r[DIV_STAGES-1][2] <= QONE)
    else $error("normal quotient above one");

endmodule

// ===== rtl/triangle_unit_normal_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_unit_normal_core: unit face normal of a triangle
// Edge vectors, exact cross product, normalization and a rounded division by
// the Euclidean length, all in one fully pipelined datapath.
// ----------------------------------------------------------------------------
// The core takes one triangle in every clock cycle and never raises busy, so
// a transfer completes at any edge where start is high. Every triangle gives
// exactly one result, shown for one cycle with out_strobe, after the
// triangle has passed through seven front stages
// (edges, products, cross terms, bit length, normalizing shift, squares,
// sum), 32 square root stages, 16 divider stages and the output register.
// Most of the latency comes from the bit-per-stage square root and divider. The
// receiver must take every result as it comes; there is no way to hold it.
// ----------------------------------------------------------------------------
module triangle_unit_normal_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  tnorm_pkg::in_item_t  in_data,
  output logic                 out_strobe,
  output tnorm_pkg::out_item_t out_data
);
  import tnorm_pkg::*;

  // The pipeline never stalls, so a new triangle is welcome every cycle.
  assign busy = 1'b0;

  logic in_fire;
  assign in_fire = start & ~busy;

  // Stage 1: sign-extend the used coordinate bits and form both edges.
  logic signed [COORD_BITS-1:0] vtx [9];
  assign vtx[0] = signed'(in_data.v0_x[COORD_BITS-1:0]);
  assign vtx[1] = signed'(in_data.v0_y[COORD_BITS-1:0]);
  assign vtx[2] = signed'(in_data.v0_z[COORD_BITS-1:0]);
  assign vtx[3] = signed'(in_data.v1_x[COORD_BITS-1:0]);
  assign vtx[4] = signed'(in_data.v1_y[COORD_BITS-1:0]);
  assign vtx[5] = signed'(in_data.v1_z[COORD_BITS-1:0]);
  assign vtx[6] = signed'(in_data.v2_x[COORD_BITS-1:0]);
  assign vtx[7] = signed'(in_data.v2_y[COORD_BITS-1:0]);
  assign vtx[8] = signed'(in_data.v2_z[COORD_BITS-1:0]);

  logic                     vld1_r;
  logic signed [EDGE_W-1:0] e1_r [3];
  logic signed [EDGE_W-1:0] e2_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      e1_r[i] <= EDGE_W'(vtx[i])     - EDGE_W'(vtx[3 + i]);
      e2_r[i] <= EDGE_W'(vtx[3 + i]) - EDGE_W'(vtx[6 + i]);
    end
  end

  // Stage 2: the edge products that form the cross product.
  logic                     vld2_r;
  logic signed [PROD_W-1:0] p_r [3];
  logic signed [PROD_W-1:0] q_r [3];

  always_ff @(posedge clk) begin
    p_r[0] <= e1_r[1] * e2_r[2];
    q_r[0] <= e1_r[2] * e2_r[1];
    p_r[1] <= e1_r[2] * e2_r[0];
    q_r[1] <= e1_r[0] * e2_r[2];
    p_r[2] <= e1_r[0] * e2_r[1];
    q_r[2] <= e1_r[1] * e2_r[0];
  end

  // Stage 3: exact cross product components as sign and magnitude.
  logic              vld3_r;
  logic [MAG_W-1:0]  mag_r [3];
  logic [2:0]        neg3_r;
  logic signed [DIFF_W-1:0] diff [3];
  logic [DIFF_W-1:0]        absd [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = DIFF_W'(p_r[i]) - DIFF_W'(q_r[i]);
      absd[i] = diff[i][DIFF_W-1] ? DIFF_W'(-diff[i]) : DIFF_W'(diff[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag_r[i]  <= absd[i][MAG_W-1:0];
      neg3_r[i] <= diff[i][DIFF_W-1];
    end
  end

  // Stage 4: bit length of the largest magnitude, found from their union.
  logic             vld4_r;
  logic [MAG_W-1:0] mag4_r [3];
  logic [2:0]       neg4_r;
  logic [LEN_W-1:0] len4_r;
  logic [MAG_W-1:0] mag_or;
  logic [LEN_W-1:0] blen;

  always_comb begin
    mag_or = mag_r[0] | mag_r[1] | mag_r[2];
    blen   = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mag_or[i]) begin
        blen = LEN_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    mag4_r <= mag_r;
    neg4_r <= neg3_r;
    len4_r <= blen;
  end

  // Stage 5: shift all magnitudes so the largest has exactly NORM_BITS bits.
  localparam logic [LEN_W-1:0] NB = LEN_W'(NORM_BITS);

  logic       vld5_r;
  side_t      side5_r;
  logic [MAG_W-1:0] shifted [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (len4_r > NB) begin
        shifted[i] = mag4_r[i] >> (len4_r - NB);
      end else begin
        shifted[i] = mag4_r[i] << (NB - len4_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    side5_r.zero <= (len4_r == '0);
    side5_r.neg  <= neg4_r;
    for (int i = 0; i < 3; i++) begin
      side5_r.m[i] <= shifted[i][NORM_BITS-1:0];
    end
  end

  // Stage 6: squares of the normalized magnitudes.
  logic            vld6_r;
  side_t           side6_r;
  logic [SQ_W-1:0] sq_r [3];

  always_ff @(posedge clk) begin
    side6_r <= side5_r;
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= SQ_W'(side5_r.m[i]) * SQ_W'(side5_r.m[i]);
    end
  end

  // Stage 7: sum of squares, the radicand of the length.
  logic             vld7_r;
  side_t            side7_r;
  logic [SUM_W-1:0] sum_r;

  always_ff @(posedge clk) begin
    side7_r <= side6_r;
    sum_r   <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
    end else begin
      vld1_r <= in_fire;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
      vld6_r <= vld5_r;
      vld7_r <= vld6_r;
    end
  end

  // Length of the normalized vector, floor of the square root.
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side;

  tnorm_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld7_r),
    .in_val   (sum_r),
    .in_side  (side7_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // Rounded division of each magnitude by the length, with sign applied.
  logic      dv_vld;
  logic      dv_zero;
  out_item_t dv_item;

  tnorm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sq_vld),
    .in_len   (sq_root),
    .in_side  (sq_side),
    .out_vld  (dv_vld),
    .out_zero (dv_zero),
    .out_item (dv_item)
  );

  // Output register: each result is presented for exactly one cycle.
  logic      out_strobe_r;
  logic      out_zero_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= dv_item;
    out_zero_r <= dv_zero;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // Every accepted triangle yields its result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##LATENCY out_strobe)
    else $error("result missing after pipeline latency");

  // No result appears without a transfer the same latency earlier.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |-> ##LATENCY !out_strobe)
    else $error("result strobe without a matching input transfer");

  // A degenerate triangle leaves the pipeline as an all-zero normal.
  a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_zero_r |-> out_data.normal_x == '0
      && out_data.normal_y == '0 && out_data.normal_z == '0)
    else $error("degenerate triangle gave a nonzero normal");

endmodule
